### src/lwp_pkg.sv
// shared types and constants for the loop work partition bounds block
package lwp_pkg;

  localparam int CfgW   = 17;
  localparam int IdxW   = 2;
  localparam int IdW    = 16;
  localparam int WordW  = 32;
  localparam int OutW   = 64;
  localparam int ColW   = 9;
  localparam int DivBits = 4;

  typedef enum logic [1:0] {
    MODE_FLAT         = 2'd0,
    MODE_TWO_LEVEL    = 2'd1,
    MODE_BLOCK_CYCLIC = 2'd2,
    MODE_TILING_2D    = 2'd3
  } mode_e;

  typedef enum logic [IdxW-1:0] {
    CFG_MODE         = 2'd0,
    CFG_WORKER_TOTAL = 2'd1,
    CFG_NODE_WORKERS = 2'd2
  } cfg_idx_e;

  // values derived from the configuration registers
  typedef struct packed {
    logic            busy;
    logic [ColW-1:0] cols;
    logic [CfgW-1:0] tile_parts;
    logic [CfgW-1:0] nodes;
  } derived_t;

  typedef struct packed {
    mode_e mode;
    logic  nw_zero;
    logic  cyc_work;
  } tag_t;

  typedef struct packed {
    logic [WordW-1:0] iters;
    logic [WordW-1:0] blk;
  } load_t;

  typedef struct packed {
    mode_e            mode;
    logic             nw_zero;
    logic             cyc_work;
    logic [WordW-1:0] iters;
    logic [CfgW-1:0]  local_id;
    logic [OutW-1:0]  start;
    logic [OutW-1:0]  hint;
    logic [WordW-1:0] rows;
  } tail_t;

endpackage

### src/lwp_div.sv
// pipelined restoring divider, a few quotient bits per stage
module lwp_div #(
  parameter int NumW  = 32,
  parameter int DenW  = 17,
  parameter int SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [NumW-1:0]  quo_o,
  output logic [DenW-1:0]  rem_o,
  output logic [SideW-1:0] side_o
);

  localparam int StepW  = lwp_pkg::DivBits;
  localparam int StageN = (NumW + StepW - 1) / StepW;
  localparam int BitW   = $clog2(NumW);

  logic             v_q [StageN];
  logic [NumW-1:0]  n_q [StageN];
  logic [NumW-1:0]  q_q [StageN];
  logic [DenW-1:0]  d_q [StageN];
  logic [DenW-1:0]  r_q [StageN];
  logic [SideW-1:0] s_q [StageN];

  for (genvar s = 0; s < StageN; s++) begin : g_stage
    logic             v_in;
    logic [NumW-1:0]  n_in;
    logic [NumW-1:0]  q_in;
    logic [DenW-1:0]  d_in;
    logic [DenW-1:0]  r_in;
    logic [SideW-1:0] s_in;
    logic [NumW-1:0]  q_out;
    logic [DenW-1:0]  r_out;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_rest
      assign v_in = v_q[s-1];
      assign n_in = n_q[s-1];
      assign q_in = q_q[s-1];
      assign d_in = d_q[s-1];
      assign r_in = r_q[s-1];
      assign s_in = s_q[s-1];
    end

    always_comb begin
      logic [DenW:0]   t;
      logic [BitW-1:0] bi;
      int              idx;
      r_out = r_in;
      q_out = q_in;
      t     = '0;
      bi    = '0;
      idx   = 0;
      for (int k = 0; k < StepW; k++) begin
        idx = NumW - 1 - s * StepW - k;
        if (idx >= 0) begin
          bi = BitW'(idx);
          t  = {r_out, n_in[bi]};
          if (t >= {1'b0, d_in}) begin
            t         = t - {1'b0, d_in};
            q_out[bi] = 1'b1;
          end
          r_out = t[DenW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s] <= n_in;
        q_q[s] <= q_out;
        d_q[s] <= d_in;
        r_q[s] <= r_out;
        s_q[s] <= s_in;
      end
    end
  end

  assign valid_o = v_q[StageN-1];
  assign quo_o   = q_q[StageN-1];
  assign rem_o   = r_q[StageN-1];
  assign side_o  = s_q[StageN-1];

endmodule

### src/lwp_cfg.sv
// sequencer that derives grid columns, tile rows and node count from the registers
module lwp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lwp_pkg::CfgW-1:0]    worker_total_i,
  input  logic [lwp_pkg::CfgW-1:0]    node_workers_i,
  output lwp_pkg::derived_t           derived_o
);

  localparam int CW = lwp_pkg::CfgW;
  localparam int DW = 10;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_NEXT = 5'b00010,
    ST_MOD  = 5'b00100,
    ST_TILE = 5'b01000,
    ST_NODE = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [DW-1:0]             d_q, d_d;
  logic [lwp_pkg::ColW-1:0]  cols_q, cols_d;
  logic [CW-1:0]             tparts_q, tparts_d;
  logic [CW-1:0]             nodes_q, nodes_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [CW-1:0]             num_q, num_d;
  logic [CW-1:0]             den_q, den_d;
  logic [CW-1:0]             rem_q, rem_d;
  logic [CW-1:0]             quo_q, quo_d;

  logic [CW:0]               t;
  logic                      ge;
  logic [2*DW-1:0]           sq;
  logic [CW-1:0]             nw_den;

  assign t      = {rem_q, num_q[CW-1]};
  assign ge     = t >= {1'b0, den_q};
  assign sq     = d_q * d_q;
  assign nw_den = (node_workers_i == '0) ? CW'(1) : node_workers_i;

  always_comb begin
    state_d  = state_q;
    d_d      = d_q;
    cols_d   = cols_q;
    tparts_d = tparts_q;
    nodes_d  = nodes_q;
    cnt_d    = cnt_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quo_d    = quo_q;

    // one quotient bit per cycle while a division runs
    if (cnt_q != '0) begin
      rem_d = ge ? CW'(t - {1'b0, den_q}) : t[CW-1:0];
      quo_d = {quo_q[CW-2:0], ge};
      num_d = {num_q[CW-2:0], 1'b0};
      cnt_d = cnt_q - 5'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_NEXT: begin
        num_d = worker_total_i;
        rem_d = '0;
        quo_d = '0;
        cnt_d = 5'(CW);
        if (sq <= (2*DW)'(worker_total_i)) begin
          den_d   = CW'(d_q);
          state_d = ST_MOD;
        end else begin
          den_d   = CW'(cols_q);
          state_d = ST_TILE;
        end
      end
      ST_MOD: begin
        if (cnt_q == '0) begin
          if (rem_q == '0) begin
            cols_d = d_q[lwp_pkg::ColW-1:0];
          end
          d_d     = d_q + DW'(1);
          state_d = ST_NEXT;
        end
      end
      ST_TILE: begin
        if (cnt_q == '0) begin
          tparts_d = quo_q;
          num_d    = worker_total_i;
          den_d    = nw_den;
          rem_d    = '0;
          quo_d    = '0;
          cnt_d    = 5'(CW);
          state_d  = ST_NODE;
        end
      end
      ST_NODE: begin
        if (cnt_q == '0) begin
          nodes_d = (node_workers_i == '0) ? '0 : quo_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // any register write restarts the search
    if (start_i) begin
      state_d = ST_NEXT;
      d_d     = DW'(2);
      cols_d  = lwp_pkg::ColW'(1);
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      d_q      <= DW'(2);
      cols_q   <= lwp_pkg::ColW'(1);
      tparts_q <= CW'(1);
      nodes_q  <= CW'(1);
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      d_q      <= d_d;
      cols_q   <= cols_d;
      tparts_q <= tparts_d;
      nodes_q  <= nodes_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign derived_o.busy       = (state_q != ST_IDLE);
  assign derived_o.cols       = cols_q;
  assign derived_o.tile_parts = tparts_q;
  assign derived_o.nodes      = nodes_q;

endmodule

### src/loop_work_partition_bounds_core.sv
// top level of the loop work partition bounds block
// Usage: a worker query (worker_index, iteration_total, chunk_total, block_length)
// enters on the in channel (in_valid_i / in_stall_o) and one result item with
// the slice, has_work flag and acquire window leaves on the out channel
// (out_valid_o / out_stall_i). An item is taken when valid is high and stall low.
// One item per cycle is taken when the output is not stalled and no search runs,
// through the pipelined dividers (four quotient bits per stage) and the split
// 64-bit products.
// Configuration is written over cfg_we_i / cfg_index_i / cfg_data_i; the user
// must write it only while idle, which the block itself does not enforce.
// After each write a sequencer derives the grid column count, tile rows and node
// count with a one-bit-per-cycle divider, and in_stall_o stays high meanwhile.
// Reset clears valid bits and puts mode 0, one worker and one worker per node in
// place; no search runs after reset.
// When out_stall_i holds a result, the whole pipeline freezes and in_stall_o
// rises; nothing is lost or repeated.
module loop_work_partition_bounds_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwp_pkg::IdxW-1:0]      cfg_index_i,
  input  logic [lwp_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lwp_pkg::IdW-1:0]       worker_index_i,
  input  logic [lwp_pkg::WordW-1:0]     iteration_total_i,
  input  logic [lwp_pkg::WordW-1:0]     chunk_total_i,
  input  logic [lwp_pkg::WordW-1:0]     block_length_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lwp_pkg::OutW-1:0]      slice_start_o,
  output logic [lwp_pkg::OutW-1:0]      slice_count_o,
  output logic [lwp_pkg::OutW-1:0]      slice_count_hint_o,
  output logic                          has_work_o,
  output logic [lwp_pkg::OutW-1:0]      window_start_o,
  output logic [lwp_pkg::OutW-1:0]      window_size_o,
  output logic [lwp_pkg::OutW-1:0]      window_size_hint_o
);

  localparam int CW = lwp_pkg::CfgW;
  localparam int WW = lwp_pkg::WordW;
  localparam int OW = lwp_pkg::OutW;
  localparam int TagW  = $bits(lwp_pkg::tag_t);
  localparam int LoadW = $bits(lwp_pkg::load_t);
  localparam int TailW = $bits(lwp_pkg::tail_t);

  // configuration registers
  lwp_pkg::mode_e    mode_q;
  logic [CW-1:0]     wt_q;
  logic [CW-1:0]     nw_q;
  lwp_pkg::derived_t der;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lwp_pkg::MODE_FLAT;
      wt_q   <= CW'(1);
      nw_q   <= CW'(1);
    end else if (cfg_we_i) begin
      unique case (lwp_pkg::cfg_idx_e'(cfg_index_i))
        lwp_pkg::CFG_MODE:         mode_q <= lwp_pkg::mode_e'(cfg_data_i[1:0]);
        lwp_pkg::CFG_WORKER_TOTAL: wt_q   <= cfg_data_i;
        lwp_pkg::CFG_NODE_WORKERS: nw_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lwp_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (cfg_we_i),
    .worker_total_i (wt_q),
    .node_workers_i (nw_q),
    .derived_o      (der)
  );

  // pipeline control: everything advances together unless the output is held
  logic adv;
  logic accept;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv || der.busy;
  assign accept     = in_valid_i && !in_stall_o;

  // input preparation
  logic          nw_zero;
  logic [CW-1:0] nw_den;
  logic          tile_on;
  logic [CW-1:0] den_a;
  logic [CW-1:0] parts;
  logic [WW-1:0] num_b;
  logic [CW-1:0] den_b;
  lwp_pkg::tag_t  tag_in;
  lwp_pkg::load_t load_in;

  assign nw_zero = (nw_q == '0);
  assign nw_den  = nw_zero ? CW'(1) : nw_q;
  assign tile_on = (der.cols > lwp_pkg::ColW'(1));

  always_comb begin
    case (mode_q)
      lwp_pkg::MODE_TWO_LEVEL: begin
        den_a = nw_den;
        parts = der.nodes;
      end
      lwp_pkg::MODE_TILING_2D: begin
        den_a = tile_on ? CW'(der.cols) : CW'(1);
        parts = tile_on ? der.tile_parts : wt_q;
      end
      default: begin
        den_a = CW'(1);
        parts = wt_q;
      end
    endcase
  end

  // zero participants: divide zero by one so base and remainder are zero
  assign num_b = (parts == '0) ? '0 : chunk_total_i;
  assign den_b = (parts == '0) ? CW'(1) : parts;

  assign tag_in.mode     = mode_q;
  assign tag_in.nw_zero  = nw_zero;
  assign tag_in.cyc_work = (WW'(worker_index_i) < chunk_total_i);
  assign load_in.iters   = iteration_total_i;
  assign load_in.blk     = block_length_i;

  // id split (worker / node / row) and chunk share run side by side
  logic             a_v, b_v;
  logic [WW-1:0]    a_quo, b_quo;
  logic [CW-1:0]    a_rem, b_rem;
  logic [TagW-1:0]  a_side;
  logic [LoadW-1:0] b_side;

  lwp_div #(.NumW(WW), .DenW(CW), .SideW(TagW)) u_div_id (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (accept),
    .num_i   (WW'(worker_index_i)),
    .den_i   (den_a),
    .side_i  (tag_in),
    .valid_o (a_v),
    .quo_o   (a_quo),
    .rem_o   (a_rem),
    .side_o  (a_side)
  );

  lwp_div #(.NumW(WW), .DenW(CW), .SideW(LoadW)) u_div_chunk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (accept),
    .num_i   (num_b),
    .den_i   (den_b),
    .side_i  (load_in),
    .valid_o (b_v),
    .quo_o   (b_quo),
    .rem_o   (b_rem),
    .side_o  (b_side)
  );

  lwp_pkg::tag_t  a_tag;
  lwp_pkg::load_t b_load;
  logic [15:0]    who;
  logic           lt;

  assign a_tag  = lwp_pkg::tag_t'(a_side);
  assign b_load = lwp_pkg::load_t'(b_side);
  assign who    = a_quo[15:0];
  assign lt     = ({1'b0, who} < b_rem);

  // m1: chunk count, id * base and remainder offset
  logic           m1_v_q;
  lwp_pkg::tag_t  m1_tag_q;
  lwp_pkg::load_t m1_load_q;
  logic [CW-1:0]  m1_lid_q;
  logic [WW:0]    m1_count_q;
  logic [47:0]    m1_prod_q;
  logic [15:0]    m1_add_q;

  // m2: chunk start
  logic           m2_v_q;
  lwp_pkg::tag_t  m2_tag_q;
  lwp_pkg::load_t m2_load_q;
  logic [CW-1:0]  m2_lid_q;
  logic [WW:0]    m2_count_q;
  logic [48:0]    m2_cstart_q;

  // m3: partial products by block length
  logic           m3_v_q;
  lwp_pkg::tag_t  m3_tag_q;
  lwp_pkg::load_t m3_load_q;
  logic [CW-1:0]  m3_lid_q;
  logic [OW-1:0]  m3_sl_q;
  logic [WW-1:0]  m3_sh_q;
  logic [OW-1:0]  m3_cl_q;
  logic           m3_ch_q;

  // m4: 64-bit start and hint
  logic           m4_v_q;
  lwp_pkg::tag_t  m4_tag_q;
  logic [WW-1:0]  m4_iters_q;
  logic [CW-1:0]  m4_lid_q;
  logic [OW-1:0]  m4_start_q;
  logic [OW-1:0]  m4_hint_q;

  // m5: clamp to the loop end
  logic           m5_v_q;
  lwp_pkg::tag_t  m5_tag_q;
  logic [WW-1:0]  m5_iters_q;
  logic [CW-1:0]  m5_lid_q;
  logic [OW-1:0]  m5_start_q;
  logic [OW-1:0]  m5_hint_q;
  logic [WW-1:0]  m5_rows_q;

  // m6: ceiling numerator for the local split
  logic           m6_v_q;
  lwp_pkg::tail_t m6_tail_q;
  logic [WW:0]    m6_num_q;

  logic [48:0]    sh_full;
  logic [OW-1:0]  m4_start_d;
  logic [OW-1:0]  m4_hint_d;
  logic [WW-1:0]  left5;
  logic [WW-1:0]  rows5;

  assign sh_full    = m2_cstart_q[48:32] * m2_load_q.blk;
  assign m4_start_d = m3_sl_q + {m3_sh_q, 32'd0};
  assign m4_hint_d  = m3_cl_q + (m3_ch_q ? {m3_load_q.blk, 32'd0} : OW'(0));
  assign left5      = (m4_start_q >= OW'(m4_iters_q)) ? '0 : WW'(OW'(m4_iters_q) - m4_start_q);
  assign rows5      = (m4_hint_q < OW'(left5)) ? m4_hint_q[WW-1:0] : left5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
      m5_v_q <= 1'b0;
      m6_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= a_v;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
      m4_v_q <= m3_v_q;
      m5_v_q <= m4_v_q;
      m6_v_q <= m5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_tag_q   <= a_tag;
      m1_load_q  <= b_load;
      m1_lid_q   <= a_rem;
      m1_count_q <= lt ? ((WW+1)'(b_quo) + (WW+1)'(1)) : (WW+1)'(b_quo);
      m1_prod_q  <= 48'(who) * 48'(b_quo);
      m1_add_q   <= lt ? who : b_rem[15:0];

      m2_tag_q    <= m1_tag_q;
      m2_load_q   <= m1_load_q;
      m2_lid_q    <= m1_lid_q;
      m2_count_q  <= m1_count_q;
      m2_cstart_q <= 49'(m1_prod_q) + 49'(m1_add_q);

      m3_tag_q  <= m2_tag_q;
      m3_load_q <= m2_load_q;
      m3_lid_q  <= m2_lid_q;
      m3_sl_q   <= OW'(m2_cstart_q[31:0]) * OW'(m2_load_q.blk);
      m3_sh_q   <= sh_full[WW-1:0];
      m3_cl_q   <= OW'(m2_count_q[31:0]) * OW'(m2_load_q.blk);
      m3_ch_q   <= m2_count_q[WW];

      m4_tag_q   <= m3_tag_q;
      m4_iters_q <= m3_load_q.iters;
      m4_lid_q   <= m3_lid_q;
      m4_start_q <= m4_start_d;
      m4_hint_q  <= m4_hint_d;

      m5_tag_q   <= m4_tag_q;
      m5_iters_q <= m4_iters_q;
      m5_lid_q   <= m4_lid_q;
      m5_start_q <= m4_start_q;
      m5_hint_q  <= m4_hint_q;
      m5_rows_q  <= rows5;

      m6_tail_q.mode     <= m5_tag_q.mode;
      m6_tail_q.nw_zero  <= m5_tag_q.nw_zero;
      m6_tail_q.cyc_work <= m5_tag_q.cyc_work;
      m6_tail_q.iters    <= m5_iters_q;
      m6_tail_q.local_id <= m5_lid_q;
      m6_tail_q.start    <= m5_start_q;
      m6_tail_q.hint     <= m5_hint_q;
      m6_tail_q.rows     <= m5_rows_q;
      m6_num_q           <= (WW+1)'(m5_rows_q) + (WW+1)'(nw_den - CW'(1));
    end
  end

  // ceiling split of the node's rows over its local threads
  logic             c_v;
  logic [WW:0]      c_quo;
  logic [CW-1:0]    c_rem;
  logic [TailW-1:0] c_side;

  lwp_div #(.NumW(WW+1), .DenW(CW), .SideW(TailW)) u_div_sub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m6_v_q),
    .num_i   (m6_num_q),
    .den_i   (nw_den),
    .side_i  (m6_tail_q),
    .valid_o (c_v),
    .quo_o   (c_quo),
    .rem_o   (c_rem),
    .side_o  (c_side)
  );

  // p1: local start
  logic           p1_v_q;
  lwp_pkg::tail_t p1_tail_q;
  logic [WW:0]    p1_sub_q;
  logic [49:0]    p1_ls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= c_v;
    end
  end

  lwp_pkg::tail_t c_tail;
  assign c_tail = lwp_pkg::tail_t'(c_side);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_tail_q <= c_tail;
      p1_sub_q  <= c_quo;
      p1_ls_q   <= 50'(c_tail.local_id) * 50'(c_quo);
    end
  end

  // final selection by mode
  logic [WW-1:0] left_l;
  logic [WW:0]   cnt_l;
  logic [OW-1:0] s_start_d, s_count_d, s_hint_d, w_start_d, w_size_d, w_hint_d;
  logic          work_d;

  assign left_l = (p1_ls_q >= 50'(p1_tail_q.rows)) ? '0
                : WW'(50'(p1_tail_q.rows) - p1_ls_q);
  assign cnt_l  = (p1_sub_q < (WW+1)'(left_l)) ? p1_sub_q : (WW+1)'(left_l);

  always_comb begin
    s_start_d = '0;
    s_count_d = '0;
    s_hint_d  = '0;
    w_start_d = '0;
    w_size_d  = '0;
    w_hint_d  = '0;
    work_d    = 1'b0;
    case (p1_tail_q.mode)
      lwp_pkg::MODE_BLOCK_CYCLIC: begin
        work_d   = p1_tail_q.cyc_work;
        w_size_d = OW'(p1_tail_q.iters);
        w_hint_d = OW'(p1_tail_q.iters);
      end
      lwp_pkg::MODE_TWO_LEVEL: begin
        if (!p1_tail_q.nw_zero) begin
          w_start_d = p1_tail_q.start;
          w_hint_d  = p1_tail_q.hint;
          w_size_d  = OW'(p1_tail_q.rows);
          s_hint_d  = OW'(p1_sub_q);
          s_count_d = OW'(cnt_l);
          s_start_d = p1_tail_q.start + OW'(p1_ls_q);
          work_d    = (cnt_l != '0);
        end
      end
      default: begin
        s_start_d = p1_tail_q.start;
        s_hint_d  = p1_tail_q.hint;
        s_count_d = OW'(p1_tail_q.rows);
        work_d    = (p1_tail_q.rows != '0);
        w_start_d = p1_tail_q.start;
        w_size_d  = OW'(p1_tail_q.rows);
        w_hint_d  = p1_tail_q.hint;
      end
    endcase
  end

  logic [OW-1:0] s_start_q, s_count_q, s_hint_q, w_start_q, w_size_q, w_hint_q;
  logic          work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_start_q <= s_start_d;
      s_count_q <= s_count_d;
      s_hint_q  <= s_hint_d;
      work_q    <= work_d;
      w_start_q <= w_start_d;
      w_size_q  <= w_size_d;
      w_hint_q  <= w_hint_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign slice_start_o      = s_start_q;
  assign slice_count_o      = s_count_q;
  assign slice_count_hint_o = s_hint_q;
  assign has_work_o         = work_q;
  assign window_start_o     = w_start_q;
  assign window_size_o      = w_size_q;
  assign window_size_hint_o = w_hint_q;

  // the two parallel dividers must stay in lockstep
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_v == b_v)
    else $error("id and chunk dividers out of step");

  // the derived-value search only starts from a register write
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(der.busy) |-> $past(cfg_we_i))
    else $error("derived search started without a write");

  // grid column count is never zero
  a_cols_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    der.cols != '0)
    else $error("grid column count is zero");

endmodule

### verif/lwp_checker.sv
// checker for the loop work partition bounds block: predicts each result and compares it
module lwp_checker
  import lwp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [IdW-1:0]   worker_index_i,
  input  logic [WordW-1:0] iteration_total_i,
  input  logic [WordW-1:0] chunk_total_i,
  input  logic [WordW-1:0] block_length_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [OutW-1:0]  slice_start_i,
  input  logic [OutW-1:0]  slice_count_i,
  input  logic [OutW-1:0]  slice_count_hint_i,
  input  logic             has_work_i,
  input  logic [OutW-1:0]  window_start_i,
  input  logic [OutW-1:0]  window_size_i,
  input  logic [OutW-1:0]  window_size_hint_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               items_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [OutW-1:0] word_t;

  typedef struct {
    word_t slice_start;
    word_t slice_count;
    word_t slice_hint;
    logic  has_work;
    word_t win_start;
    word_t win_size;
    word_t win_hint;
  } bounds_t;

  mode_e cur_mode;
  word_t cur_workers;
  word_t cur_node_workers;
  bounds_t bounds_q[$];

  function automatic void share(input word_t chunks, input word_t parts, input word_t id,
                                output word_t first, output word_t cnt);
    word_t base, rem;
    base = 0;
    rem  = 0;
    if (parts != 0) begin
      base = chunks / parts;
      rem  = chunks % parts;
    end
    cnt   = (id < rem) ? base + 1 : base;
    first = id * base + ((id < rem) ? id : rem);
  endfunction

  function automatic word_t clamp_end(word_t first, word_t len, word_t total);
    word_t left;
    left = (first >= total) ? 0 : total - first;
    return (len < left) ? len : left;
  endfunction

  function automatic word_t grid_cols(word_t total);
    word_t best;
    best = 1;
    if (total < 4) return 1;
    for (word_t d = 2; d * d <= total; d++)
      if (total % d == 0) best = d;
    return best;
  endfunction

  function automatic bounds_t partition(word_t id, word_t iters, word_t chunks, word_t blk);
    bounds_t r;
    word_t c_start, c_count, rows, sub, loc_start, parts, who, cols;
    r = '{default: 0};
    if (cur_mode == MODE_BLOCK_CYCLIC) begin
      r.has_work = id < chunks;
      r.win_size = iters;
      r.win_hint = iters;
    end else if (cur_mode == MODE_TWO_LEVEL) begin
      if (cur_node_workers != 0) begin
        share(chunks, cur_workers / cur_node_workers, id / cur_node_workers, c_start, c_count);
        r.win_start = c_start * blk;
        r.win_hint  = c_count * blk;
        rows = clamp_end(r.win_start, r.win_hint, iters);
        r.win_size = rows;
        sub = (rows + (cur_node_workers - 1)) / cur_node_workers;
        loc_start = (id % cur_node_workers) * sub;
        r.slice_count = clamp_end(loc_start, sub, rows);
        r.slice_hint  = sub;
        r.slice_start = r.win_start + loc_start;
        r.has_work    = r.slice_count > 0;
      end
    end else begin
      parts = cur_workers;
      who   = id;
      if (cur_mode == MODE_TILING_2D) begin
        cols = grid_cols(cur_workers);
        if (cols > 1) begin
          parts = cur_workers / cols;
          who   = id / cols;
        end
      end
      share(chunks, parts, who, c_start, c_count);
      r.slice_start = c_start * blk;
      r.slice_hint  = c_count * blk;
      r.slice_count = clamp_end(r.slice_start, r.slice_hint, iters);
      r.has_work    = r.slice_count > 0;
      r.win_start   = r.slice_start;
      r.win_size    = r.slice_count;
      r.win_hint    = r.slice_hint;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input word_t got, input word_t want);
    $display("mismatch on %s: got %h, want %h", field, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    items_seen_o = 0;
  end

  assign pending_o = bounds_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bounds_t want;
    if (!rst_ni) begin
      cur_mode         <= MODE_FLAT;
      cur_workers      <= 1;
      cur_node_workers <= 1;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bounds_q.size() == 0) begin
          $display("result item with nothing expected");
          fail_count_o++;
        end else begin
          want = bounds_q.pop_front();
          if (slice_start_i !== want.slice_start)
            flag_mismatch("slice_start", slice_start_i, want.slice_start);
          if (slice_count_i !== want.slice_count)
            flag_mismatch("slice_count", slice_count_i, want.slice_count);
          if (slice_count_hint_i !== want.slice_hint)
            flag_mismatch("slice_count_hint", slice_count_hint_i, want.slice_hint);
          if (has_work_i !== want.has_work)
            flag_mismatch("has_work", has_work_i, want.has_work);
          if (window_start_i !== want.win_start)
            flag_mismatch("window_start", window_start_i, want.win_start);
          if (window_size_i !== want.win_size)
            flag_mismatch("window_size", window_size_i, want.win_size);
          if (window_size_hint_i !== want.win_hint)
            flag_mismatch("window_size_hint", window_size_hint_i, want.win_hint);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        bounds_q.push_back(partition(worker_index_i, iteration_total_i, chunk_total_i,
                                     block_length_i));
        items_seen_o++;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:         cur_mode <= mode_e'(cfg_data_i[1:0]);
          CFG_WORKER_TOTAL: cur_workers <= cfg_data_i;
          CFG_NODE_WORKERS: cur_node_workers <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

### verif/tb.sv
// testbench top for the loop work partition bounds block: stimulus and verdict
module tb;
  import lwp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 60000;
  localparam int Drain = 40;

  logic clk, rst_n;
  logic cfg_we;
  logic [IdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [IdW-1:0] worker_index;
  logic [WordW-1:0] iteration_total, chunk_total, block_length;
  logic [OutW-1:0] slice_start, slice_count, slice_count_hint;
  logic [OutW-1:0] window_start, window_size, window_size_hint;
  logic has_work;
  int fail_count, pending, items_seen;
  int send_pct, recv_pct, idle_cycles;
  bit hold_req;
  int hold_left;

  loop_work_partition_bounds_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .worker_index_i(worker_index), .iteration_total_i(iteration_total),
    .chunk_total_i(chunk_total), .block_length_i(block_length),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .slice_start_o(slice_start), .slice_count_o(slice_count),
    .slice_count_hint_o(slice_count_hint), .has_work_o(has_work),
    .window_start_o(window_start), .window_size_o(window_size),
    .window_size_hint_o(window_size_hint)
  );

  lwp_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .worker_index_i(worker_index), .iteration_total_i(iteration_total),
    .chunk_total_i(chunk_total), .block_length_i(block_length),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .slice_start_i(slice_start), .slice_count_i(slice_count),
    .slice_count_hint_i(slice_count_hint), .has_work_i(has_work),
    .window_start_i(window_start), .window_size_i(window_size),
    .window_size_hint_i(window_size_hint),
    .fail_count_o(fail_count), .pending_o(pending), .items_seen_o(items_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // watchdog: cycles with no item moving and no register write
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic offer(input logic [IdW-1:0] id, input logic [WordW-1:0] iters,
                       input logic [WordW-1:0] chunks, input logic [WordW-1:0] blk);
    int gap;
    gap = 0;
    // keep drawing while the draw falls below send_pct, lengthening the idle gap each time
    while ($urandom_range(0, 99) < send_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    worker_index <= id;
    iteration_total <= iters;
    chunk_total <= chunks;
    block_length <= blk;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 0;
    wait (pending == 0);
    repeat (Drain) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  function automatic logic [WordW-1:0] pick_word(int small_max);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, small_max);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 100000);
    endcase
  endfunction

  typedef struct {
    mode_e mode;
    int workers;
    int node_workers;
  } setting_t;

  setting_t settings[14];

  initial begin
    logic [IdW-1:0] id;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_MODE;
    cfg_data = 0;
    in_valid = 0;
    out_stall = 0;
    worker_index = 0;
    iteration_total = 0;
    chunk_total = 0;
    block_length = 0;
    idle_cycles = 0;
    hold_req = 0;
    hold_left = 0;
    settings = '{
      '{MODE_FLAT, 1, 1}, '{MODE_FLAT, 0, 1}, '{MODE_FLAT, 65536, 3},
      '{MODE_TWO_LEVEL, 16, 4}, '{MODE_TWO_LEVEL, 8, 0},
      '{MODE_TWO_LEVEL, 3, 8}, '{MODE_TWO_LEVEL, 131071, 131071},
      '{MODE_BLOCK_CYCLIC, 5, 1}, '{MODE_TILING_2D, 36, 1},
      '{MODE_TILING_2D, 3, 1}, '{MODE_TILING_2D, 97, 1},
      '{MODE_TILING_2D, 65536, 1}, '{MODE_FLAT, 100, 7}, '{MODE_TILING_2D, 0, 2}
    };
    send_pct = 13;
    recv_pct = 87;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    for (int s = 0; s < 14; s++) begin
      if (s == 5) begin
        send_pct = 87;
        recv_pct = 13;
      end
      if (s == 10) begin
        send_pct = 0;
        recv_pct = 0;
        hold_req = 1;
      end
      write_reg(CFG_MODE, CfgW'(settings[s].mode));
      write_reg(CFG_WORKER_TOTAL, CfgW'(settings[s].workers));
      write_reg(CFG_NODE_WORKERS, CfgW'(settings[s].node_workers));
      @(negedge clk);
      cfg_we <= 0;
      // extremes of every field
      offer(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer(16'hFFFF, 0, 0, 0);
      for (int n = 0; n < 78; n++) begin
        id = ($urandom_range(0, 3) == 0) ? IdW'($urandom())
                                         : IdW'($urandom_range(0, settings[s].workers + 3));
        offer(id, pick_word(300), pick_word(64),
              ($urandom_range(0, 9) == 0) ? 32'd0 : pick_word(16));
      end
      settle();
    end

    $display("covered %0d items over 14 register settings in all four modes,", items_seen);
    $display("with sender and receiver idling in turn and one long receiver hold-off");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
